// ===== hdl/piu_pkg.sv =====
// Shared types, widths, register codes and helpers of the palette upscaler.
package piu_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 27;
  localparam int ADDR_W     = 26;
  localparam int COLOR_W    = 16;
  localparam int INDEX_W    = 8;
  localparam int POS_W      = 10;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_COLUMN    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_ROW       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES  = 4'd7;

  // Item modes
  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_PIXEL   = 1'b1;

  typedef struct packed {
    logic [10:0] source_width;
    logic [10:0] source_height;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [11:0] pan_column;
    logic [12:0] pan_row;
    logic [14:0] line_stride;
    logic [26:0] buffer_bytes;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    source_width:  11'd256,
    source_height: 11'd240,
    screen_width:  13'd1280,
    screen_height: 13'd720,
    pan_column:    12'd0,
    pan_row:       13'd0,
    line_stride:   15'd2560,
    buffer_bytes:  27'd67108864
  };

  // Operands of the shared multiply-add unit: res = a * b + c
  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [31:0] c;
  } mac_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE_W,
    ST_SCALE_H,
    ST_BASE_Y,
    ST_BASE_X,
    ST_ROW_MAC,
    ST_ROW_CHK,
    ST_EMIT,
    ST_DONE
  } state_e;

  // Limit a source dimension to 1..1024
  function automatic logic [10:0] clamp_src(input logic [10:0] v);
    logic [10:0] r;
    if (v == 11'd0) begin
      r = 11'd1;
    end else if (v > 11'd1024) begin
      r = 11'd1024;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hdl/piu_if.sv =====
// Handshake interfaces of the palette upscaler: items, results, configuration.
interface piu_item_if import piu_pkg::*;;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [INDEX_W-1:0] color_index;
  logic [COLOR_W-1:0] palette_color;
  logic               frame_start;

  modport source (output valid, mode, color_index, palette_color, frame_start, input ready);
  modport sink   (input valid, mode, color_index, palette_color, frame_start, output ready);
endinterface

interface piu_result_if import piu_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  write_address;
  logic [COLOR_W-1:0] write_color;
  logic               last_write;

  modport source (output valid, write_address, write_color, last_write, input ready);
  modport sink   (input valid, write_address, write_color, last_write, output ready);
endinterface

interface piu_cfg_if import piu_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/palette_integer_upscaler.sv =====
// Top level of the palette upscaler: configuration registers and unit wiring.
//
// Palette writes and source pixels arrive in raster order on the item channel;
// each pixel turns into a scale-by-scale block of 16-bit framebuffer writes on
// the result channel, at the largest scale up to MAX_SCALE that fits the screen (else 1),
// centered, with rows and columns outside the view or the buffer dropped. A
// palette write leaves the item channel ready. The first pixel after any
// register write first tries the candidate scales again, from MAX_SCALE down.
// Pixel work is serialized through the one shared multiply-add unit, which in
// turn forms the scale tests, the block origin and each row's byte offset, and
// through the result channel, which takes one write per cycle unless stalled.
// The item channel is not ready while a pixel is in progress.
// Registers may be written at any time the block is idle; the port is always
// ready.
module palette_integer_upscaler import piu_pkg::*; #(
  parameter int MAX_SCALE       = 3,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  piu_cfg_if.sink      cfg_i,
  piu_item_if.sink     item_i,
  piu_result_if.source result_o
);

  cfg_t               cfg_q;
  logic               cfg_write;
  mac_req_t           mac_req;
  logic signed [31:0] mac_res;

  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid && cfg_i.ready;

  // Register file; writes beyond the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_i.index)
        REG_SOURCE_WIDTH:  cfg_q.source_width  <= cfg_i.data[10:0];
        REG_SOURCE_HEIGHT: cfg_q.source_height <= cfg_i.data[10:0];
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_i.data[12:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_i.data[12:0];
        REG_PAN_COLUMN:    cfg_q.pan_column    <= cfg_i.data[11:0];
        REG_PAN_ROW:       cfg_q.pan_row       <= cfg_i.data[12:0];
        REG_LINE_STRIDE:   cfg_q.line_stride   <= cfg_i.data[14:0];
        REG_BUFFER_BYTES:  cfg_q.buffer_bytes  <= cfg_i.data[26:0];
        default: begin
        end
      endcase
    end
  end

  piu_seq #(
    .MAX_SCALE       (MAX_SCALE),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_write_i (cfg_write),
    .item_i      (item_i),
    .result_o    (result_o),
    .mac_req_o   (mac_req),
    .mac_res_i   (mac_res)
  );

  piu_mac u_mac (
    .req_i (mac_req),
    .res_o (mac_res)
  );

endmodule

// ===== hdl/piu_mac.sv =====
// Shared signed multiply-add unit used by the sequencer for all products.
module piu_mac import piu_pkg::*; (
  input  mac_req_t           req_i,
  output logic signed [31:0] res_o
);

  logic signed [31:0] prod;

  // Form the product in 32 bits, then add the offset
  assign prod  = req_i.a * req_i.b;
  assign res_o = prod + req_i.c;

endmodule

// ===== hdl/piu_seq.sv =====
// Sequencer, palette memory and write generator of the palette upscaler.
module piu_seq import piu_pkg::*; #(
  parameter int MAX_SCALE       = 3,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               cfg_write_i,
  piu_item_if.sink           item_i,
  piu_result_if.source       result_o,
  output mac_req_t           mac_req_o,
  input  logic signed [31:0] mac_res_i
);

  localparam int SCW = $clog2(MAX_SCALE + 1);
  localparam int PAW = $clog2(PALETTE_ENTRIES);

  state_e state_q, state_d;

  logic [POS_W-1:0]   col_q, row_q;
  logic [SCW-1:0]     scale_q, cx_q, vy_q;
  logic               geo_ok_q, first_q, next_ok_q;
  logic signed [14:0] excess_w_q, excess_h_q;
  logic signed [15:0] xb_q, y_q;
  logic signed [31:0] off_cur_q, off_nxt_q;
  logic [COLOR_W-1:0] color_q;
  logic [COLOR_W-1:0] pal_mem [PALETTE_ENTRIES];

  logic               out_valid_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_last_q;

  logic [10:0]        src_w, src_h;
  logic               item_acc, idx_ok;
  logic [PAW-1:0]     pal_addr;
  logic signed [14:0] neg_w, neg_h, x0, y0;
  logic               fit, scale_one, row_ok;
  logic signed [15:0] x;
  logic               x_ok, col_last, row_last, cx_end, more_rows;
  logic               slot_free, emit_fire, emit_step;
  logic [ADDR_W-1:0]  addr;
  logic [POS_W-1:0]   col_inc, row_inc;
  logic               col_wrap;

  // Clamped source size and input handshake
  assign src_w        = clamp_src(cfg_i.source_width);
  assign src_h        = clamp_src(cfg_i.source_height);
  assign item_i.ready = (state_q == ST_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;
  assign idx_ok       = {1'b0, item_i.color_index} < 9'(PALETTE_ENTRIES);
  assign pal_addr     = item_i.color_index[PAW-1:0];

  // Centering offsets: halve the spare space, rounding toward zero
  assign neg_w = -excess_w_q;
  assign neg_h = -excess_h_q;
  assign x0    = (neg_w + $signed({14'b0, neg_w[14]})) >>> 1;
  assign y0    = (neg_h + $signed({14'b0, neg_h[14]})) >>> 1;

  assign scale_one = (scale_q == SCW'(1));
  assign fit       = (excess_w_q <= 15'sd0) && ($signed(mac_res_i[14:0]) <= 15'sd0);

  // Row check: inside the screen and its whole span inside the buffer
  assign row_ok = (y_q >= 16'sd0) && (y_q < $signed(16'(cfg_i.screen_height))) &&
                  ((off_nxt_q + $signed(32'({cfg_i.screen_width, 1'b0}))) <=
                   $signed(32'(cfg_i.buffer_bytes)));

  // Column walk inside the current row
  assign x         = xb_q + $signed(16'(cx_q));
  assign x_ok      = (x >= 16'sd0) && (x < $signed(16'(cfg_i.screen_width)));
  assign cx_end    = (cx_q == scale_q - SCW'(1));
  assign col_last  = cx_end || ((x + 16'sd1) >= $signed(16'(cfg_i.screen_width)));
  assign row_last  = (vy_q == scale_q - SCW'(1)) || !next_ok_q;
  assign more_rows = ({1'b0, vy_q} + (SCW + 1)'(2)) < {1'b0, scale_q};
  assign addr      = off_cur_q[ADDR_W-1:0] + ADDR_W'({x[12:0], 1'b0});

  assign slot_free = !out_valid_q || result_o.ready;
  assign emit_fire = (state_q == ST_EMIT) && x_ok && slot_free;
  assign emit_step = (state_q == ST_EMIT) && (!x_ok || slot_free);

  // Source position advance
  assign col_inc  = col_q + POS_W'(1);
  assign row_inc  = row_q + POS_W'(1);
  assign col_wrap = ({1'b0, col_inc} >= src_w) || (col_inc == '0);

  // Operand select for the shared multiply-add unit
  always_comb begin
    mac_req_o = '0;
    case (state_q)
      ST_SCALE_W: begin
        mac_req_o.a = $signed(16'(src_w));
        mac_req_o.b = $signed(16'(scale_q));
        mac_req_o.c = -$signed(32'(cfg_i.screen_width));
      end
      ST_SCALE_H: begin
        mac_req_o.a = $signed(16'(src_h));
        mac_req_o.b = $signed(16'(scale_q));
        mac_req_o.c = -$signed(32'(cfg_i.screen_height));
      end
      ST_BASE_Y: begin
        mac_req_o.a = $signed(16'(row_q));
        mac_req_o.b = $signed(16'(scale_q));
        mac_req_o.c = 32'(y0);
      end
      ST_BASE_X: begin
        mac_req_o.a = $signed(16'(col_q));
        mac_req_o.b = $signed(16'(scale_q));
        mac_req_o.c = 32'(x0);
      end
      ST_ROW_MAC: begin
        mac_req_o.a = $signed(16'(cfg_i.pan_row)) + y_q;
        mac_req_o.b = $signed(16'(cfg_i.line_stride));
        mac_req_o.c = $signed(32'({cfg_i.pan_column, 1'b0}));
      end
      default: begin
        mac_req_o = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_acc && (item_i.mode == MODE_PIXEL)) begin
          state_d = geo_ok_q ? ST_BASE_Y : ST_SCALE_W;
        end
      end
      ST_SCALE_W: state_d = ST_SCALE_H;
      ST_SCALE_H: begin
        state_d = (fit || scale_one) ? ST_BASE_Y : ST_SCALE_W;
      end
      ST_BASE_Y:  state_d = ST_BASE_X;
      ST_BASE_X:  state_d = ST_ROW_MAC;
      ST_ROW_MAC: state_d = ST_ROW_CHK;
      ST_ROW_CHK: begin
        if (first_q) begin
          if (!row_ok) begin
            state_d = ST_DONE;
          end else if (scale_one) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_ROW_MAC;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_step && cx_end) begin
          if (row_last) begin
            state_d = ST_DONE;
          end else if (more_rows) begin
            state_d = ST_ROW_MAC;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers: position, scale, counters, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      scale_q     <= SCW'(MAX_SCALE);
      cx_q        <= '0;
      vy_q        <= '0;
      geo_ok_q    <= 1'b0;
      first_q     <= 1'b0;
      next_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the cached geometry on any register write
      if (cfg_write_i) begin
        geo_ok_q <= 1'b0;
      end else if ((state_q == ST_SCALE_H) && (fit || scale_one)) begin
        geo_ok_q <= 1'b1;
      end

      case (state_q)
        ST_IDLE: begin
          if (item_acc) begin
            if (item_i.frame_start) begin
              col_q <= '0;
              row_q <= '0;
            end
            if ((item_i.mode == MODE_PIXEL) && !geo_ok_q) begin
              scale_q <= SCW'(MAX_SCALE);
            end
          end
        end
        ST_SCALE_H: begin
          if (!(fit || scale_one)) begin
            scale_q <= scale_q - SCW'(1);
          end
        end
        ST_BASE_X: begin
          cx_q    <= '0;
          vy_q    <= '0;
          first_q <= 1'b1;
        end
        ST_ROW_CHK: begin
          if (first_q) begin
            first_q   <= 1'b0;
            next_ok_q <= 1'b0;
          end else begin
            next_ok_q <= row_ok;
          end
        end
        ST_EMIT: begin
          if (emit_step) begin
            if (cx_end) begin
              cx_q <= '0;
              vy_q <= vy_q + SCW'(1);
            end else begin
              cx_q <= cx_q + SCW'(1);
            end
          end
        end
        ST_DONE: begin
          if (col_wrap) begin
            col_q <= '0;
            row_q <= ({1'b0, row_inc} >= src_h) ? '0 : row_inc;
          end else begin
            col_q <= col_inc;
          end
        end
        default: begin
        end
      endcase

      // Hold the result until taken, load a new one when the slot frees
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Palette memory: write on palette items, registered read on pixels
  always_ff @(posedge clk_i) begin
    if (item_acc && (item_i.mode == MODE_PALETTE) && idx_ok) begin
      pal_mem[pal_addr] <= item_i.palette_color;
    end
    if (item_acc) begin
      color_q <= idx_ok ? pal_mem[pal_addr] : '0;
    end
  end

  // Datapath registers fed by the shared unit
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_SCALE_W: excess_w_q <= mac_res_i[14:0];
      ST_SCALE_H: excess_h_q <= mac_res_i[14:0];
      ST_BASE_Y:  y_q        <= mac_res_i[15:0];
      ST_BASE_X:  xb_q       <= mac_res_i[15:0];
      ST_ROW_MAC: off_nxt_q  <= mac_res_i;
      ST_ROW_CHK: begin
        if (first_q) begin
          off_cur_q <= off_nxt_q;
          y_q       <= y_q + 16'sd1;
        end
      end
      ST_EMIT: begin
        if (emit_step && cx_end && !row_last) begin
          off_cur_q <= off_nxt_q;
          y_q       <= y_q + 16'sd1;
        end
      end
      default: begin
      end
    endcase

    if (emit_fire) begin
      out_addr_q  <= addr;
      out_color_q <= color_q;
      out_last_q  <= col_last && row_last;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.write_address = out_addr_q;
  assign result_o.write_color   = out_color_q;
  assign result_o.last_write    = out_last_q;

endmodule

// ===== hdl/piu_chk.sv =====
// Port-level assertions of the palette upscaler and their bind to the top level.
module piu_chk import piu_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               item_valid_i,
  input logic               item_ready_i,
  input logic               item_mode_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [ADDR_W-1:0]  out_address_i,
  input logic [COLOR_W-1:0] out_color_i,
  input logic               out_last_i
);

  // Hold a stalled result transaction unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_address_i) &&
      $stable(out_color_i) && $stable(out_last_i))
    else $error("stalled result changed or vanished");

  // Drop ready once a pixel is taken
  a_busy_after_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && item_ready_i && (item_mode_i == MODE_PIXEL) |=> !item_ready_i)
    else $error("item channel ready while a pixel is in progress");

  // Keep ready across a palette write
  a_palette_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && item_ready_i && (item_mode_i == MODE_PALETTE) |=> item_ready_i)
    else $error("palette write stalled the item channel");

  // Start a new result only while a pixel is in progress
  a_result_from_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!item_ready_i))
    else $error("result appeared with no pixel in progress");

endmodule

bind palette_integer_upscaler piu_chk u_piu_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .item_valid_i  (item_i.valid),
  .item_ready_i  (item_i.ready),
  .item_mode_i   (item_i.mode),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_address_i (result_o.write_address),
  .out_color_i   (result_o.write_color),
  .out_last_i    (result_o.last_write)
);

// ===== tb/testbench.sv =====
// Self-checking testbench of the palette upscaler: directed table, then randomized layouts.
`timescale 1ns / 1ps

module testbench import piu_pkg::*;;

  localparam int SCALE_MAX   = 3;
  localparam int PAL_DEPTH   = 256;
  localparam int NUM_REGS    = 8;
  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE      = 40;
  localparam int PHASE_ITEMS = 36;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [NUM_REGS] = '{
    REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT, REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT,
    REG_PAN_COLUMN, REG_PAN_ROW, REG_LINE_STRIDE, REG_BUFFER_BYTES
  };

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               last;
  } fb_write_t;

  // One row of the directed walk; typed rows carry the block origin and color
  typedef struct {
    logic               mode;
    logic [INDEX_W-1:0] idx;
    logic [COLOR_W-1:0] pcolor;
    logic               fstart;
    logic               typed;
    logic [ADDR_W-1:0]  addr0;
    logic [COLOR_W-1:0] rgb;
  } walk_row_t;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LIGHT} stall_e;

  logic clk_i;
  logic rst_ni;

  piu_item_if   item_bus ();
  piu_result_if result_bus ();
  piu_cfg_if    cfg_bus ();

  palette_integer_upscaler #(
    .MAX_SCALE      (SCALE_MAX),
    .PALETTE_ENTRIES(PAL_DEPTH)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_bus),
    .item_i  (item_bus),
    .result_o(result_bus)
  );

  // Predictor state
  cfg_t               regs_now;
  logic [COLOR_W-1:0] palette_copy [PAL_DEPTH];
  int                 col_at;
  int                 row_at;
  fb_write_t          writes_due [$];

  // Palette entries already written; pixels only look these up
  logic               pal_seen [PAL_DEPTH];
  logic [INDEX_W-1:0] pal_list [$];

  int burst_left;
  int mismatches;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint src_dim(input logic [10:0] v);
    if (v == 11'd0) return 1;
    if (v > 11'd1024) return 1024;
    return longint'(v);
  endfunction

  // Whether screen row y is in view and inside the buffer; its byte offset goes to off
  function automatic bit row_open(input longint y, output longint off);
    if (y < 0 || y >= longint'(regs_now.screen_height)) return 1'b0;
    off = (longint'(regs_now.pan_row) + y) * longint'(regs_now.line_stride)
          + longint'(regs_now.pan_column) * 2;
    if (off + longint'(regs_now.screen_width) * 2 > longint'(regs_now.buffer_bytes))
      return 1'b0;
    return 1'b1;
  endfunction

  // Update the predictor for one accepted transaction and queue its writes
  task automatic upscale_item(input logic mode, input logic [INDEX_W-1:0] idx,
                              input logic [COLOR_W-1:0] pcolor, input logic fstart);
    longint    w, h, sw, sh, x0, y0, base_y, off, x;
    int        scale;
    fb_write_t blk [$];
    fb_write_t wr;
    if (fstart) begin
      col_at = 0;
      row_at = 0;
    end
    if (mode == MODE_PALETTE) begin
      palette_copy[idx] = pcolor;
      return;
    end
    w  = src_dim(regs_now.source_width);
    h  = src_dim(regs_now.source_height);
    sw = longint'(regs_now.screen_width);
    sh = longint'(regs_now.screen_height);
    scale = SCALE_MAX;
    while (scale > 1 && (w * scale > sw || h * scale > sh)) scale--;
    x0 = (sw - w * scale) / 2;
    y0 = (sh - h * scale) / 2;
    base_y = y0 + longint'(row_at) * scale;
    // Drop the whole block when its first row is not writable
    if (row_open(base_y, off)) begin
      for (int vy = 0; vy < scale; vy++) begin
        if (vy == 0 || row_open(base_y + vy, off)) begin
          for (int dx = 0; dx < scale; dx++) begin
            x = x0 + longint'(col_at) * scale + dx;
            if (x >= 0 && x < sw) begin
              wr.addr  = ADDR_W'(off + x * 2);
              wr.color = palette_copy[idx];
              wr.last  = 1'b0;
              blk.push_back(wr);
            end
          end
        end
      end
    end
    if (blk.size() > 0) blk[blk.size()-1].last = 1'b1;
    foreach (blk[i]) writes_due.push_back(blk[i]);
    // Advance the raster position, wrapping line and frame
    col_at = (col_at + 1) & 10'h3FF;
    if (col_at >= w || col_at == 0) begin
      col_at = 0;
      row_at = (row_at + 1) & 10'h3FF;
      if (row_at >= h) row_at = 0;
    end
  endtask

  // Present one transaction in a burst, wait for acceptance, then predict it
  task automatic send_item(input logic mode, input logic [INDEX_W-1:0] idx,
                           input logic [COLOR_W-1:0] pcolor, input logic fstart);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    item_bus.valid         <= 1'b1;
    item_bus.mode          <= mode;
    item_bus.color_index   <= idx;
    item_bus.palette_color <= pcolor;
    item_bus.frame_start   <= fstart;
    do @(posedge clk_i); while (!item_bus.ready);
    if (mode == MODE_PALETTE && !pal_seen[idx]) begin
      pal_seen[idx] = 1'b1;
      pal_list.push_back(idx);
    end
    upscale_item(mode, idx, pcolor, fstart);
  endtask

  // Hold the sender until every queued write has arrived
  task automatic drain(input int settle);
    item_bus.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (writes_due.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] reg_value(input cfg_t c,
                                                      input logic [CFG_IDX_W-1:0] r);
    case (r)
      REG_SOURCE_WIDTH:  return CFG_DATA_W'(c.source_width);
      REG_SOURCE_HEIGHT: return CFG_DATA_W'(c.source_height);
      REG_SCREEN_WIDTH:  return CFG_DATA_W'(c.screen_width);
      REG_SCREEN_HEIGHT: return CFG_DATA_W'(c.screen_height);
      REG_PAN_COLUMN:    return CFG_DATA_W'(c.pan_column);
      REG_PAN_ROW:       return CFG_DATA_W'(c.pan_row);
      REG_LINE_STRIDE:   return CFG_DATA_W'(c.line_stride);
      default:           return c.buffer_bytes;
    endcase
  endfunction

  // Write every register back to back, then drop valid
  task automatic load_layout(input cfg_t c);
    for (int r = 0; r < NUM_REGS; r++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= REG_ORDER[r];
      cfg_bus.data  <= reg_value(c, REG_ORDER[r]);
      do @(posedge clk_i); while (!cfg_bus.ready);
    end
    cfg_bus.valid <= 1'b0;
    regs_now = c;
  endtask

  function automatic cfg_t make_layout(input int srcw, input int srch, input int scrw,
                                       input int scrh, input int pcol, input int prow,
                                       input int stride, input int span_bytes);
    cfg_t c;
    c.source_width  = 11'(srcw);
    c.source_height = 11'(srch);
    c.screen_width  = 13'(scrw);
    c.screen_height = 13'(scrh);
    c.pan_column    = 12'(pcol);
    c.pan_row       = 13'(prow);
    c.line_stride   = 15'(stride);
    c.buffer_bytes  = 27'(span_bytes);
    return c;
  endfunction

  // Mostly small frames so that line and frame wraps occur, now and then full-range fields
  function automatic cfg_t random_layout();
    return make_layout(
      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 12),
      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 6),
      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 40),
      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 24),
      $urandom_range(0, 4095),
      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 64),
      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 200),
      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4000) : $urandom_range(0, 27'h7FFFFFF));
  endfunction

  // Mostly pixels that read written entries, mixed with palette updates and frame restarts
  task automatic random_item();
    logic fs;
    fs = ($urandom_range(0, 24) == 0);
    if ($urandom_range(0, 99) < 22) begin
      send_item(MODE_PALETTE, INDEX_W'($urandom_range(0, 255)), COLOR_W'($urandom), fs);
    end else begin
      send_item(MODE_PIXEL, pal_list[$urandom_range(0, pal_list.size() - 1)],
                COLOR_W'($urandom), fs);
    end
  endtask

  // Receiver: ready follows a stall pattern that changes after each random-length span
  initial begin : result_stall
    stall_e pat;
    int     span;
    result_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      pat  = stall_e'($urandom_range(0, 3));
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(posedge clk_i);
        case (pat)
          STALL_NONE:  result_bus.ready <= 1'b1;
          STALL_HALF:  result_bus.ready <= 1'($urandom_range(0, 1));
          STALL_HEAVY: result_bus.ready <= ($urandom_range(0, 3) == 0);
          default:     result_bus.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare each accepted write with the oldest expected one
  always @(posedge clk_i) begin
    fb_write_t exp_wr;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (writes_due.size() == 0) begin
        $error("unexpected write: write_address %0h write_color %0h last_write %0b",
               result_bus.write_address, result_bus.write_color, result_bus.last_write);
        mismatches++;
      end else begin
        exp_wr = writes_due.pop_front();
        if (result_bus.write_address !== exp_wr.addr) begin
          $error("write_address: expected %0h, got %0h", exp_wr.addr,
                 result_bus.write_address);
          mismatches++;
        end
        if (result_bus.write_color !== exp_wr.color) begin
          $error("write_color: expected %0h, got %0h", exp_wr.color, result_bus.write_color);
          mismatches++;
        end
        if (result_bus.last_write !== exp_wr.last) begin
          $error("last_write: expected %0b, got %0b", exp_wr.last, result_bus.last_write);
          mismatches++;
        end
      end
    end
  end

  // End the run when no transaction moves on any channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    walk_row_t walk [13];
    cfg_t      layouts [7];
    cfg_t      phase_cfg;
    rst_ni                 <= 1'b0;
    item_bus.valid         <= 1'b0;
    item_bus.mode          <= MODE_PALETTE;
    item_bus.color_index   <= '0;
    item_bus.palette_color <= '0;
    item_bus.frame_start   <= 1'b0;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.index          <= REG_SOURCE_WIDTH;
    cfg_bus.data           <= '0;
    idle_cycles            = 0;
    mismatches             = 0;
    burst_left             = 0;
    col_at                 = 0;
    row_at                 = 0;
    regs_now               = CFG_RESET;
    foreach (palette_copy[i]) palette_copy[i] = '0;
    foreach (pal_seen[i]) pal_seen[i] = 1'b0;

    // Reset layout: scale 3, image centered at column 256, stride 2560
    walk = '{
      '{MODE_PALETTE, 8'hFF, 16'hFFFF, 1'b0, 1'b0, 26'd0,   16'h0000},
      '{MODE_PALETTE, 8'h00, 16'h0000, 1'b0, 1'b0, 26'd0,   16'h0000},
      '{MODE_PALETTE, 8'h5A, 16'hA5A5, 1'b0, 1'b0, 26'd0,   16'h0000},
      '{MODE_PALETTE, 8'hA5, 16'h5A5A, 1'b0, 1'b0, 26'd0,   16'h0000},
      '{MODE_PIXEL,   8'hFF, 16'h0000, 1'b1, 1'b1, 26'd512, 16'hFFFF},
      // palette color on a pixel is ignored
      '{MODE_PIXEL,   8'h00, 16'hFFFF, 1'b0, 1'b1, 26'd518, 16'h0000},
      '{MODE_PIXEL,   8'h5A, 16'h1234, 1'b0, 1'b1, 26'd524, 16'hA5A5},
      // frame restart carried by a palette write
      '{MODE_PALETTE, 8'h01, 16'h8001, 1'b1, 1'b0, 26'd0,   16'h0000},
      '{MODE_PIXEL,   8'h01, 16'h0000, 1'b0, 1'b1, 26'd512, 16'h8001},
      '{MODE_PIXEL,   8'hA5, 16'h0000, 1'b0, 1'b0, 26'd0,   16'h0000},
      '{MODE_PIXEL,   8'hA5, 16'h0000, 1'b1, 1'b1, 26'd512, 16'h5A5A},
      '{MODE_PALETTE, 8'hFF, 16'h7FFE, 1'b0, 1'b0, 26'd0,   16'h0000},
      '{MODE_PIXEL,   8'hFF, 16'h0000, 1'b0, 1'b0, 26'd0,   16'h0000}
    };

    layouts = '{
      // scale 3 at the top left, widest column pan
      make_layout(4, 3, 12, 9, 4095, 100, 16384, 67108864),
      // source sizes clamped to 1 x 1024, minimum stride, buffer cuts the lower rows
      make_layout(0, 2047, 1, 4096, 0, 0, 2, 3100),
      // source larger than screen: negative origins, edge rows and columns dropped
      make_layout(9, 5, 7, 2, 3, 2, 64, 1000000),
      // scale 2 with the buffer ending inside a block
      make_layout(5, 4, 11, 9, 1, 3, 30, 200),
      // empty buffer: every pixel drops all its writes
      make_layout(3, 2, 9, 6, 0, 0, 64, 0),
      // offsets past 2^26 wrap in the address
      make_layout(8, 1, 4095, 1, 4095, 3000, 32767, 27'h7FFFFFF),
      // largest source on the largest listed screen, deepest row pan
      make_layout(1024, 1024, 4096, 4096, 0, 8191, 2, 67108864)
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk; typed rows replace the predicted block with the hand-read one
    foreach (walk[k]) begin
      send_item(walk[k].mode, walk[k].idx, walk[k].pcolor, walk[k].fstart);
      if (walk[k].typed) begin
        repeat (SCALE_MAX * SCALE_MAX) void'(writes_due.pop_back());
        for (int vy = 0; vy < SCALE_MAX; vy++) begin
          for (int dx = 0; dx < SCALE_MAX; dx++) begin
            writes_due.push_back('{
              addr:  walk[k].addr0 + ADDR_W'(vy * int'(regs_now.line_stride) + dx * 2),
              color: walk[k].rgb,
              last:  (vy == SCALE_MAX - 1 && dx == SCALE_MAX - 1)
            });
          end
        end
      end
    end

    // Fixed layouts first, then random ones; reconfigure only when idle
    for (int p = 0; p < 10; p++) begin
      drain(SETTLE);
      phase_cfg = (p < 7) ? layouts[p] : random_layout();
      load_layout(phase_cfg);
      @(posedge clk_i);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) drain(0);
        random_item();
      end
    end

    drain(SETTLE);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
